### rtl/core/fcpq_pkg.sv
// Shared types and constants of the four-class priority queue.
package fcpq_pkg;

  localparam int unsigned NUM_CLASSES  = 4;
  localparam int unsigned CLASS_W      = 2;
  localparam int unsigned TICKET_W     = 16;
  localparam int unsigned TIME_W       = 11;
  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned COUNT_W      = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_ARRIVE = 2'd0,
    ACT_SERVE  = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_BAD_CLASS = 3'd2,
    ST_SERVED    = 3'd3,
    ST_NONE      = 3'd4,
    ST_QUERY     = 3'd5
  } status_e;

  // Classified command handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_SERVE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] ticket;
    logic [2:0]  priority_class;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } in_t;

  typedef struct packed {
    status_e            status_code;
    logic [15:0]        served_ticket;
    logic [1:0]         served_class;
    logic signed [11:0] wait_minutes;
    logic [4:0]         queue_length;
    logic [15:0]        class_served;
    logic [15:0]        total_served;
    logic [6:0]         peak_occupancy;
    logic [10:0]        max_wait;
  } out_t;

  typedef struct packed {
    op_e                 op;
    logic [CLASS_W-1:0]  cls;
    logic [TICKET_W-1:0] ticket;
    logic [TIME_W-1:0]   minutes;
  } cmd_t;

endpackage

### rtl/core/fcpq_front.sv
// Front end: takes input beats, converts time to minutes, classifies.
module fcpq_front import fcpq_pkg::*; (
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  logic unused_act;
  logic bad_cls;

  // Action three is swallowed here and never reaches the back.
  assign unused_act  = (in_i.action == ACT_UNUSED);
  assign bad_cls     = in_i.priority_class[2];
  assign in_ready_o  = cmd_ready_i || unused_act;
  assign cmd_valid_o = in_valid_i && !unused_act;

  always_comb begin
    cmd_o.cls     = in_i.priority_class[CLASS_W-1:0];
    cmd_o.ticket  = in_i.ticket;
    cmd_o.minutes = TIME_W'(in_i.hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(in_i.minute);
    case (in_i.action)
      ACT_ARRIVE: cmd_o.op = bad_cls ? OP_BAD : OP_ARRIVE;
      ACT_SERVE:  cmd_o.op = OP_SERVE;
      ACT_QUERY:  cmd_o.op = bad_cls ? OP_BAD : OP_QUERY;
      default:    cmd_o.op = OP_BAD;
    endcase
  end

endmodule

### rtl/core/fcpq_cmd_fifo.sv
// Two-entry command queue between front and back.
module fcpq_cmd_fifo import fcpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

### rtl/core/fcpq_back.sv
// Back end: class queues in an entry memory, statistics, result register.
module fcpq_back import fcpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TOT_W     = CNT_W + 2;
  localparam int unsigned TKT_W     = (TICKET_BITS < TICKET_W) ? TICKET_BITS : TICKET_W;
  localparam int unsigned ENTRY_W   = TKT_W + TIME_W;
  localparam int unsigned ADDR_W    = PTR_W + CLASS_W;
  localparam int unsigned MEM_DEPTH = NUM_CLASSES << PTR_W;

  localparam logic S_EXEC = 1'b0;
  localparam logic S_READ = 1'b1;

  logic [PTR_W-1:0]   head_q [NUM_CLASSES];
  logic [PTR_W-1:0]   head_d [NUM_CLASSES];
  logic [PTR_W-1:0]   tail_q [NUM_CLASSES];
  logic [PTR_W-1:0]   tail_d [NUM_CLASSES];
  logic [CNT_W-1:0]   cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0]   cnt_d  [NUM_CLASSES];
  logic [COUNT_W-1:0] served_q [NUM_CLASSES];
  logic [COUNT_W-1:0] served_d [NUM_CLASSES];
  logic [COUNT_W-1:0] total_q, total_d;
  logic [TOT_W-1:0]   peak_q, peak_d;
  logic [TIME_W-1:0]  wpeak_q, wpeak_d;
  logic               state_q, state_d;
  logic [CLASS_W-1:0] pick_q, pick_d;
  logic [TIME_W-1:0]  now_q, now_d;

  logic [ENTRY_W-1:0] mem_q [MEM_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic               out_valid_q;
  out_t               out_q;
  out_t               res;
  logic               load_out;
  logic               out_free;
  logic               fire;

  logic               any_waiting;
  logic [CLASS_W-1:0] pick_cls;
  logic [TOT_W-1:0]   occ_total;
  logic [TOT_W-1:0]   occ_next;
  logic [11:0]        wait_val;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_EXEC) && out_free;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Strict priority: lowest non-empty class wins.
  always_comb begin
    any_waiting = 1'b0;
    pick_cls    = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cnt_q[c] != '0) begin
        any_waiting = 1'b1;
        pick_cls    = CLASS_W'(c);
      end
    end
  end

  always_comb begin
    occ_total = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      occ_total = occ_total + TOT_W'(cnt_q[c]);
    end
    occ_next = occ_total + 1'b1;
  end

  assign wait_val = 12'(now_q) - 12'(rdata_q[TIME_W-1:0]);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    served_d  = served_q;
    total_d   = total_q;
    peak_d    = peak_q;
    wpeak_d   = wpeak_q;
    state_d   = state_q;
    pick_d    = pick_q;
    now_d     = now_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {cmd_i.cls, tail_q[cmd_i.cls]};
    mem_raddr = {pick_cls, head_q[pick_cls]};
    mem_wdata = {cmd_i.ticket[TKT_W-1:0], cmd_i.minutes};
    load_out  = 1'b0;
    res       = '0;

    if (state_q == S_READ) begin
      if (out_free) begin
        if ($signed(wait_val) > $signed({1'b0, wpeak_q})) begin
          wpeak_d = wait_val[TIME_W-1:0];
        end
        res.status_code   = ST_SERVED;
        res.served_ticket = TICKET_W'(rdata_q[ENTRY_W-1:TIME_W]);
        res.served_class  = pick_q;
        res.wait_minutes  = $signed(wait_val);
        load_out          = 1'b1;
        state_d           = S_EXEC;
      end
    end else if (fire) begin
      case (cmd_i.op)
        OP_ARRIVE: begin
          load_out = 1'b1;
          if (cnt_q[cmd_i.cls] == CNT_W'(QUEUE_DEPTH)) begin
            res.status_code = ST_DROPPED;
          end else begin
            mem_we = 1'b1;
            tail_d[cmd_i.cls] = (tail_q[cmd_i.cls] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                '0 : tail_q[cmd_i.cls] + 1'b1;
            cnt_d[cmd_i.cls]  = cnt_q[cmd_i.cls] + 1'b1;
            if (occ_next > peak_q) begin
              peak_d = occ_next;
            end
            res.status_code = ST_QUEUED;
          end
        end
        OP_SERVE: begin
          if (!any_waiting) begin
            res.status_code = ST_NONE;
            load_out        = 1'b1;
          end else begin
            mem_re = 1'b1;
            head_d[pick_cls] = (head_q[pick_cls] == PTR_W'(QUEUE_DEPTH - 1)) ?
                               '0 : head_q[pick_cls] + 1'b1;
            cnt_d[pick_cls]  = cnt_q[pick_cls] - 1'b1;
            if (served_q[pick_cls] != COUNT_MAX) begin
              served_d[pick_cls] = served_q[pick_cls] + 1'b1;
            end
            if (total_q != COUNT_MAX) begin
              total_d = total_q + 1'b1;
            end
            pick_d  = pick_cls;
            now_d   = cmd_i.minutes;
            state_d = S_READ;
          end
        end
        OP_QUERY: begin
          res.status_code  = ST_QUERY;
          res.queue_length = 5'(cnt_q[cmd_i.cls]);
          res.class_served = served_q[cmd_i.cls];
          load_out         = 1'b1;
        end
        default: begin
          res.status_code = ST_BAD_CLASS;
          load_out        = 1'b1;
        end
      endcase
    end

    // Global statistics after this beat's update.
    res.total_served   = total_d;
    res.peak_occupancy = 7'(peak_d);
    res.max_wait       = wpeak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]   <= '0;
        tail_q[c]   <= '0;
        cnt_q[c]    <= '0;
        served_q[c] <= '0;
      end
      total_q     <= '0;
      peak_q      <= '0;
      wpeak_q     <= '0;
      state_q     <= S_EXEC;
      out_valid_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      served_q <= served_d;
      total_q  <= total_d;
      peak_q   <= peak_d;
      wpeak_q  <= wpeak_d;
      state_q  <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
    now_q  <= now_d;
    if (load_out) begin
      out_q <= res;
    end
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule

### rtl/core/four_class_priority_queue.sv
// Top level of the four-class strict priority queue.
//
// Four FIFO ticket queues (classes V, A, D, B = 0..3, class 0 highest) share
// one entry memory of 4 x QUEUE_DEPTH entries holding ticket and arrival time
// in minutes. Each input beat is an arrival, a serve or a query; every beat
// except action three yields exactly one result beat carrying the global
// statistics after that beat's update. Arrivals to a full class queue are
// dropped (status dropped), unknown classes report bad class, serves pick the
// head of the lowest-numbered non-empty queue and report the signed wait.
// Served counters saturate at 65535. The front converts time and classifies
// in the cycle the beat is accepted and hands it through a two-entry command
// queue to the back. The back retires an arrival, a query, a bad-class beat
// or a serve with nothing waiting in the cycle it takes the beat; a serve
// that finds an entry then waits in a read state for the registered read of
// the entry memory. A result held in the output register does not stop the
// front from taking beats until the command queue fills. The entry memory
// needs no clearing after reset, so beats are accepted from the first cycle.
module four_class_priority_queue import fcpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  fcpq_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  fcpq_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_i       (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_o        (bk_cmd)
  );

  fcpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TICKET_BITS (TICKET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bk_valid),
    .cmd_ready_o (bk_ready),
    .cmd_i       (bk_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

### dv/four_class_priority_queue_tb.sv
// Testbench for the four-class priority queue: directed table, random bursts, back-to-back tail.
`timescale 1ns / 100ps

module four_class_priority_queue_tb;
  import fcpq_pkg::*;

  localparam int unsigned QDEPTH       = 16;
  localparam int unsigned RANDOM_ITEMS = 740;
  localparam int unsigned TAIL_PAIRS   = 16;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  // Flavor of a random burst.
  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN,
    MIX_NOISE
  } mix_e;

  // One row of the directed table. Typed rows carry a status whose other fields
  // are all zero; every other row is checked against the predictor.
  typedef struct {
    in_t     beat;
    bit      typed;
    status_e status;
  } row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_beat   = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_t out_beat;

  four_class_priority_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .TICKET_BITS(TICKET_W)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the four ticket queues and the statistics.
  // ---------------------------------------------------------------------------
  bit [TICKET_W-1:0] ticket_mem  [NUM_CLASSES][QDEPTH];
  bit [TIME_W-1:0]   arrival_mem [NUM_CLASSES][QDEPTH];
  int unsigned       q_head  [NUM_CLASSES];
  int unsigned       q_tail  [NUM_CLASSES];
  int unsigned       q_count [NUM_CLASSES];
  bit [COUNT_W-1:0]  served_cls [NUM_CLASSES];
  bit [COUNT_W-1:0]  served_all;
  bit [6:0]          occ_peak;
  bit [10:0]         wait_hi;

  out_t        outcomes_due[$];   // results owed by the block, oldest first
  row_t        script[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned gap_pct    = 0;    // odds (percent) of a sender gap before a beat
  int unsigned stall_pct  = 0;    // odds (percent) of a receiver stall burst
  int unsigned stall_left = 0;

  function automatic int unsigned waiting_total();
    int unsigned sum;
    sum = 0;
    for (int c = 0; c < NUM_CLASSES; c++) sum += q_count[c];
    return sum;
  endfunction

  // Applies one input beat to the shadow queues; returns 0 when the beat
  // produces no result (the unused action).
  function automatic bit queue_outcome(input in_t b, output out_t r);
    bit [TIME_W-1:0] now;
    int unsigned     cls;
    int              pick;
    int              waited;
    r    = '0;
    now  = TIME_W'(b.hour * MIN_PER_HOUR + b.minute);
    cls  = b.priority_class;
    pick = -1;
    case (b.action)
      ACT_ARRIVE: begin
        if (cls >= NUM_CLASSES) begin
          r.status_code = ST_BAD_CLASS;
        end else if (q_count[cls] >= QDEPTH) begin
          r.status_code = ST_DROPPED;
        end else begin
          ticket_mem[cls][q_tail[cls]]  = b.ticket;
          arrival_mem[cls][q_tail[cls]] = now;
          q_tail[cls] = (q_tail[cls] + 1) % QDEPTH;
          q_count[cls]++;
          r.status_code = ST_QUEUED;
        end
        // peak tracks every arrival, dropped or not
        if (waiting_total() > occ_peak) occ_peak = 7'(waiting_total());
      end
      ACT_SERVE: begin
        // strict priority: lowest-numbered non-empty class wins
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
          if (q_count[c] != 0) pick = c;
        end
        if (pick < 0) begin
          r.status_code = ST_NONE;
        end else begin
          waited = int'(now) - int'(arrival_mem[pick][q_head[pick]]);
          r.status_code   = ST_SERVED;
          r.served_ticket = ticket_mem[pick][q_head[pick]];
          r.served_class  = 2'(pick);
          r.wait_minutes  = 12'(waited);
          q_head[pick] = (q_head[pick] + 1) % QDEPTH;
          q_count[pick]--;
          if (served_cls[pick] != COUNT_MAX) served_cls[pick]++;
          if (served_all != COUNT_MAX) served_all++;
          // negative waits never raise the peak
          if (waited > int'(wait_hi)) wait_hi = 11'(waited);
        end
      end
      ACT_QUERY: begin
        if (cls >= NUM_CLASSES) begin
          r.status_code = ST_BAD_CLASS;
        end else begin
          r.status_code  = ST_QUERY;
          r.queue_length = 5'(q_count[cls]);
          r.class_served = served_cls[cls];
        end
      end
      default: return 1'b0;
    endcase
    r.total_served   = served_all;
    r.peak_occupancy = occ_peak;
    r.max_wait       = wait_hi;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_t beat_of(input action_e act, input logic [15:0] tkt,
                                  input logic [2:0] cls, input logic [4:0] hr,
                                  input logic [5:0] mn);
    in_t b;
    b.action         = act;
    b.ticket         = tkt;
    b.priority_class = cls;
    b.hour           = hr;
    b.minute         = mn;
    return b;
  endfunction

  function automatic in_t random_beat(input mix_e mix);
    in_t         b;
    int unsigned roll;
    roll     = $urandom_range(0, 99);
    b.ticket = 16'($urandom);
    if ($urandom_range(0, 15) == 0) b.priority_class = 3'($urandom_range(4, 7));
    else b.priority_class = 3'($urandom_range(0, 3));
    // mostly real clock times, sometimes the whole field range
    if ($urandom_range(0, 9) == 0) begin
      b.hour   = 5'($urandom);
      b.minute = 6'($urandom);
    end else begin
      b.hour   = 5'($urandom_range(0, 23));
      b.minute = 6'($urandom_range(0, 59));
    end
    case (mix)
      MIX_FILL: begin
        if (roll < 80) b.action = ACT_ARRIVE;
        else if (roll < 95) b.action = ACT_SERVE;
        else b.action = ACT_QUERY;
      end
      MIX_DRAIN: begin
        if (roll < 20) b.action = ACT_ARRIVE;
        else if (roll < 90) b.action = ACT_SERVE;
        else b.action = ACT_QUERY;
      end
      MIX_EVEN: begin
        if (roll < 45) b.action = ACT_ARRIVE;
        else if (roll < 85) b.action = ACT_SERVE;
        else b.action = ACT_QUERY;
      end
      default: begin
        b.action         = action_e'($urandom_range(0, 3));
        b.priority_class = 3'($urandom);
      end
    endcase
    return b;
  endfunction

  task automatic add_row(input in_t beat, input bit typed, input status_e status);
    row_t row;
    row.beat   = beat;
    row.typed  = typed;
    row.status = status;
    script.push_back(row);
  endtask

  // Drives one beat, holds it until accepted, then books the result it owes.
  // Called at a rising edge; returns at the edge of acceptance.
  task automatic send_beat(input in_t beat, input bit typed, input status_e status);
    out_t resp;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (!in_ready);
    if (queue_outcome(beat, resp)) begin
      if (typed) begin
        resp = '0;
        resp.status_code = status;
      end
      outcomes_due.push_back(resp);
    end
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outcomes_due.size() != 0);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  task automatic check_outcome(input out_t want, input out_t got);
    report_field("status_code",    want.status_code,    got.status_code);
    report_field("served_ticket",  want.served_ticket,  got.served_ticket);
    report_field("served_class",   want.served_class,   got.served_class);
    report_field("wait_minutes",   want.wait_minutes,   got.wait_minutes);
    report_field("queue_length",   want.queue_length,   got.queue_length);
    report_field("class_served",   want.class_served,   got.class_served);
    report_field("total_served",   want.total_served,   got.total_served);
    report_field("peak_occupancy", want.peak_occupancy, got.peak_occupancy);
    report_field("max_wait",       want.max_wait,       got.max_wait);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready drops in stall bursts at the current odds.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end else if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(1, 12);
      out_ready  <= 1'b0;
    end
  end

  // Result beats are taken at the edge and matched against the oldest booking.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (outcomes_due.size() == 0) begin
        mismatches++;
        $error("result beat with nothing owed, status_code %0d", out_beat.status_code);
      end else begin
        check_outcome(outcomes_due.pop_front(), out_beat);
      end
    end
  end

  // Watchdog: far above the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("four_class_priority_queue: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_t         beat;
    mix_e        mix;
    int unsigned sent;
    int unsigned next_pause;
    int unsigned roll;
    int unsigned len;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Rows right after reset carry their result in place:
    // nothing waiting, an empty query and bad classes leave all stats at zero.
    add_row(beat_of(ACT_SERVE,  16'h0000, 3'd0, 5'd0,  6'd0),  1'b1, ST_NONE);
    add_row(beat_of(ACT_QUERY,  16'h0000, 3'd0, 5'd0,  6'd0),  1'b1, ST_QUERY);
    add_row(beat_of(ACT_QUERY,  16'h0000, 3'd7, 5'd0,  6'd0),  1'b1, ST_BAD_CLASS);
    add_row(beat_of(ACT_ARRIVE, 16'hffff, 3'd4, 5'd23, 6'd59), 1'b1, ST_BAD_CLASS);
    // unused action: no result at all
    add_row(beat_of(ACT_UNUSED, 16'hffff, 3'd7, 5'd31, 6'd63), 1'b0, ST_QUEUED);
    // arrivals to every class (two to class 3), extreme tickets and times (31:63 is out of range)
    add_row(beat_of(ACT_ARRIVE, 16'h0000, 3'd3, 5'd0,  6'd0),  1'b0, ST_QUEUED);
    add_row(beat_of(ACT_ARRIVE, 16'h8001, 3'd2, 5'd31, 6'd63), 1'b0, ST_QUEUED);
    add_row(beat_of(ACT_ARRIVE, 16'h7ffe, 3'd1, 5'd12, 6'd30), 1'b0, ST_QUEUED);
    add_row(beat_of(ACT_ARRIVE, 16'hffff, 3'd0, 5'd23, 6'd59), 1'b0, ST_QUEUED);
    add_row(beat_of(ACT_ARRIVE, 16'h5555, 3'd3, 5'd0,  6'd1),  1'b0, ST_QUEUED);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      add_row(beat_of(ACT_QUERY, 16'h0000, 3'(c), 5'd0, 6'd0), 1'b0, ST_QUERY);
    end
    // serves in priority order: large negative wait, positive, most negative,
    // largest positive, positive, then an empty serve with nonzero statistics
    add_row(beat_of(ACT_SERVE,  16'h0000, 3'd0, 5'd0,  6'd0),  1'b0, ST_SERVED);
    add_row(beat_of(ACT_SERVE,  16'h0000, 3'd5, 5'd31, 6'd63), 1'b0, ST_SERVED);
    add_row(beat_of(ACT_SERVE,  16'h0000, 3'd0, 5'd0,  6'd0),  1'b0, ST_SERVED);
    add_row(beat_of(ACT_SERVE,  16'h0000, 3'd0, 5'd31, 6'd63), 1'b0, ST_SERVED);
    add_row(beat_of(ACT_SERVE,  16'h0000, 3'd0, 5'd23, 6'd59), 1'b0, ST_SERVED);
    add_row(beat_of(ACT_SERVE,  16'h0000, 3'd0, 5'd10, 6'd0),  1'b0, ST_NONE);
    add_row(beat_of(ACT_QUERY,  16'h0000, 3'd6, 5'd0,  6'd0),  1'b0, ST_BAD_CLASS);
    add_row(beat_of(ACT_ARRIVE, 16'h1234, 3'd7, 5'd1,  6'd1),  1'b0, ST_BAD_CLASS);
    add_row(beat_of(ACT_QUERY,  16'h0000, 3'd3, 5'd0,  6'd0),  1'b0, ST_QUERY);

    gap_pct   = 20;
    stall_pct = 15;
    foreach (script[i]) send_beat(script[i].beat, script[i].typed, script[i].status);
    wait_idle();

    // Overfill every class (two drops each), so the peak reaches all entries,
    // then drain past empty.
    for (int c = 0; c < NUM_CLASSES; c++) begin
      repeat (QDEPTH + 2) begin
        beat = random_beat(MIX_FILL);
        beat.action         = ACT_ARRIVE;
        beat.priority_class = 3'(c);
        send_beat(beat, 1'b0, ST_QUEUED);
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      send_beat(beat_of(ACT_QUERY, 16'h0000, 3'(c), 5'd0, 6'd0), 1'b0, ST_QUERY);
    end
    wait_idle();
    repeat (NUM_CLASSES * QDEPTH + 2) begin
      beat = random_beat(MIX_DRAIN);
      beat.action = ACT_SERVE;
      send_beat(beat, 1'b0, ST_QUEUED);
    end

    // Random bursts: mostly fill/drain runs with random content, some noise.
    // Sender and receiver odds change per burst, zero included.
    sent       = 0;
    next_pause = 300;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) mix = MIX_FILL;
      else if (roll < 65) mix = MIX_DRAIN;
      else if (roll < 85) mix = MIX_EVEN;
      else mix = MIX_NOISE;
      len       = $urandom_range(1, 24);
      gap_pct   = 8 * $urandom_range(0, 3);
      stall_pct = 8 * $urandom_range(0, 3);
      repeat (len) begin
        beat = random_beat(mix);
        send_beat(beat, 1'b0, ST_QUEUED);
        if (beat.action != ACT_UNUSED) sent++;
      end
      if (sent >= next_pause) begin
        wait_idle();
        next_pause += 300;
      end
    end

    // Last part, no idling: empty all queues, then back-to-back arrive/serve
    // pairs on class 3, the lowest priority.
    gap_pct   = 0;
    stall_pct = 0;
    while (waiting_total() != 0) begin
      send_beat(beat_of(ACT_SERVE, 16'h0000, 3'd0, 5'($urandom_range(0, 23)),
                        6'($urandom_range(0, 59))), 1'b0, ST_QUEUED);
    end
    repeat (TAIL_PAIRS) begin
      send_beat(beat_of(ACT_ARRIVE, 16'($urandom), 3'd3, 5'($urandom_range(0, 23)),
                        6'($urandom_range(0, 59))), 1'b0, ST_QUEUED);
      send_beat(beat_of(ACT_SERVE, 16'h0000, 3'd0, 5'($urandom_range(0, 23)),
                        6'($urandom_range(0, 59))), 1'b0, ST_QUEUED);
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      send_beat(beat_of(ACT_QUERY, 16'h0000, 3'(c), 5'd0, 6'd0), 1'b0, ST_QUERY);
    end
    send_beat(beat_of(ACT_SERVE, 16'h0000, 3'd0, 5'd0, 6'd0), 1'b0, ST_NONE);

    // Drain, then watch the idle outputs for stray result beats.
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("four_class_priority_queue: match");
    end else begin
      $display("four_class_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/fcpq_pkg.sv
rtl/core/fcpq_front.sv
rtl/core/fcpq_cmd_fifo.sv
rtl/core/fcpq_back.sv
rtl/core/four_class_priority_queue.sv
dv/four_class_priority_queue_tb.sv
